### hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// rational divide and compare unit.
// ----------------------------------------------------------------------------
package rdc_pkg;

	// Operand and derived widths
	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int RESULT_W      = 32;
	localparam int OPCODE_W      = 3;
	localparam int DIV_CNT_W     = $clog2(PROD_W + 1);
	localparam int DSEL_W        = 2;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_REDUCE  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_DIVIDE  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_EQUAL   = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_GREATER = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_LESS    = 3'd4;

	// Divider operand selects
	localparam logic [DSEL_W-1:0] DSEL_GCD = 2'd0;  // x / y for the next Euclid step
	localparam logic [DSEL_W-1:0] DSEL_NUM = 2'd1;  // numerator / gcd
	localparam logic [DSEL_W-1:0] DSEL_DEN = 2'd2;  // denominator / gcd

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
	typedef logic signed [PROD_W-1:0]        prod_t;
	typedef logic signed [RESULT_W-1:0]      result_t;
	typedef logic [OPCODE_W-1:0]             opcode_t;

	// Controller to datapath
	typedef struct packed {
		logic              load_in;
		logic              mul_first;
		logic              mul_second;
		logic              seed;
		logic              cmp_load;
		logic              div_start;
		logic [DSEL_W-1:0] div_sel;
		logic              gcd_step;
		logic              quot_num_load;
		logic              quot_den_load;
		logic              err_set;
		logic              out_load;
	} rdc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    x_zero;
		logic    y_zero;
		logic    div_busy;
		logic    div_done;
	} rdc_sts_t;

endpackage

### hw/rtl/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider
// Iterative signed divider, one quotient bit per cycle, with C truncating
// semantics: quotient rounds toward zero, remainder takes the dividend's sign.
// ----------------------------------------------------------------------------
module rdc_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rdc_pkg::prod_t dividend,
	input  rdc_pkg::prod_t divisor,
	output logic           busy,
	output logic           done,
	output rdc_pkg::prod_t quotient,
	output rdc_pkg::prod_t remainder
);
	import rdc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [PROD_W-1:0]    dvs_q;
	logic                 qneg_q;
	logic                 rneg_q;

	logic [PROD_W-1:0]    mag_a;
	logic [PROD_W-1:0]    mag_b;
	logic [PROD_W:0]      shifted;
	logic [PROD_W:0]      trial;

	// Take magnitudes of the operands
	assign mag_a = dividend[PROD_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
	assign mag_b = divisor[PROD_W-1]  ? $unsigned(-divisor)  : $unsigned(divisor);

	// Shift in the next dividend bit and trial-subtract
	assign shifted = {rem_q, quo_q[PROD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	// Control: step counter, busy and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring shift-subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= mag_a;
			dvs_q  <= mag_b;
			qneg_q <= dividend[PROD_W-1] ^ divisor[PROD_W-1];
			rneg_q <= dividend[PROD_W-1];
		end else if (busy_q) begin
			if (!trial[PROD_W]) begin
				rem_q <= trial[PROD_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[PROD_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	// Restore signs
	assign quotient  = qneg_q ? prod_t'(-quo_q) : prod_t'(quo_q);
	assign remainder = rneg_q ? prod_t'(-rem_q) : prod_t'(rem_q);
	assign busy      = busy_q;
	assign done      = done_q;

endmodule

### hw/rtl/rdc_datapath.sv
// ----------------------------------------------------------------------------
// rdc_datapath
// Operand registers, shared multiplier, Euclid registers, shared divider and
// the result/output registers of the rational divide and compare unit.
// ----------------------------------------------------------------------------
module rdc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  rdc_pkg::rdc_cmd_t  cmd,
	output rdc_pkg::rdc_sts_t  sts,
	input  rdc_pkg::opcode_t   opcode,
	input  rdc_pkg::operand_t  num_first,
	input  rdc_pkg::operand_t  den_first,
	input  rdc_pkg::operand_t  num_second,
	input  rdc_pkg::operand_t  den_second,
	output rdc_pkg::result_t   num_result,
	output rdc_pkg::result_t   den_result,
	output logic               compare_true,
	output logic               zero_gcd_error
);
	import rdc_pkg::*;

	opcode_t  op_q;
	operand_t p_q, q_q, r_q, s_q;
	prod_t    prod1_q, prod2_q;
	prod_t    n_q, d_q, x_q, y_q;
	result_t  res_num_q, res_den_q;
	logic     res_cmp_q, res_err_q;
	result_t  out_num_q, out_den_q;
	logic     out_cmp_q, out_err_q;

	operand_t mul_a, mul_b;
	prod_t    prod_w;
	prod_t    seed_n, seed_d;
	logic     cmp_w;
	prod_t    div_a, div_b;
	prod_t    div_quot, div_rem;
	logic     div_busy, div_done;

	// Shared multiplier: p*s on the first pass, q*r on the second
	assign mul_a  = cmd.mul_first ? p_q : q_q;
	assign mul_b  = cmd.mul_first ? s_q : r_q;
	assign prod_w = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Pick the pair to reduce
	assign seed_n = (op_q == OP_DIVIDE) ? prod1_q : PROD_W'(p_q);
	assign seed_d = (op_q == OP_DIVIDE) ? prod2_q : PROD_W'(q_q);

	// Comparisons
	always_comb begin
		case (op_q)
			OP_EQUAL:   cmp_w = (p_q == r_q) && (q_q == s_q);
			OP_GREATER: cmp_w = prod1_q > prod2_q;
			OP_LESS:    cmp_w = prod1_q < prod2_q;
			default:    cmp_w = 1'b0;
		endcase
	end

	// Divider operand select
	always_comb begin
		case (cmd.div_sel)
			DSEL_NUM: begin
				div_a = n_q;
				div_b = x_q;
			end
			DSEL_DEN: begin
				div_a = d_q;
				div_b = x_q;
			end
			default: begin
				div_a = x_q;
				div_b = y_q;
			end
		endcase
	end

	rdc_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Operand, product and Euclid registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= opcode;
			p_q  <= num_first;
			q_q  <= den_first;
			r_q  <= num_second;
			s_q  <= den_second;
		end
		if (cmd.mul_first) begin
			prod1_q <= prod_w;
		end
		if (cmd.mul_second) begin
			prod2_q <= prod_w;
		end
		if (cmd.seed) begin
			n_q <= seed_n;
			d_q <= seed_d;
			x_q <= seed_n;
			y_q <= seed_d;
		end else if (cmd.gcd_step) begin
			x_q <= y_q;
			y_q <= div_rem;
		end
	end

	// Working result registers, cleared per item
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_num_q <= '0;
			res_den_q <= '0;
			res_cmp_q <= 1'b0;
			res_err_q <= 1'b0;
		end else begin
			if (cmd.cmp_load) begin
				res_cmp_q <= cmp_w;
			end
			if (cmd.err_set) begin
				res_err_q <= 1'b1;
			end
			if (cmd.quot_num_load) begin
				res_num_q <= RESULT_W'(div_quot);
			end
			if (cmd.quot_den_load) begin
				res_den_q <= RESULT_W'(div_quot);
			end
		end
	end

	// Output register: holds the beat while the receiver stalls
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_num_q <= res_num_q;
			out_den_q <= res_den_q;
			out_cmp_q <= res_cmp_q;
			out_err_q <= res_err_q;
		end
	end

	assign num_result     = out_num_q;
	assign den_result     = out_den_q;
	assign compare_true   = out_cmp_q;
	assign zero_gcd_error = out_err_q;

	assign sts.op       = op_q;
	assign sts.x_zero   = (x_q == '0);
	assign sts.y_zero   = (y_q == '0);
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;

endmodule

### hw/rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer for the rational divide and compare unit: input and output
// handshakes, multiply passes, Euclid loop and the two reducing divisions.
// ----------------------------------------------------------------------------
module rdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rdc_pkg::rdc_cmd_t cmd,
	input  rdc_pkg::rdc_sts_t sts
);
	import rdc_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_MUL1     = 4'd1;
	localparam logic [3:0] ST_MUL2     = 4'd2;
	localparam logic [3:0] ST_DISPATCH = 4'd3;
	localparam logic [3:0] ST_CHECK    = 4'd4;
	localparam logic [3:0] ST_GCD      = 4'd5;
	localparam logic [3:0] ST_DIVN     = 4'd6;
	localparam logic [3:0] ST_DIVD     = 4'd7;
	localparam logic [3:0] ST_FINISH   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul_first = 1'b1;
				state_d       = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_second = 1'b1;
				state_d        = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				unique case (sts.op) inside
					OP_REDUCE, OP_DIVIDE: begin
						cmd.seed = 1'b1;
						state_d  = ST_CHECK;
					end
					OP_EQUAL, OP_GREATER, OP_LESS: begin
						cmd.cmp_load = 1'b1;
						state_d      = ST_FINISH;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_CHECK: begin
				if (!sts.y_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_GCD;
					state_d       = ST_GCD;
				end else if (sts.x_zero) begin
					cmd.err_set = 1'b1;
					state_d     = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DSEL_NUM;
					state_d       = ST_DIVN;
				end
			end
			ST_GCD: begin
				if (sts.div_done) begin
					cmd.gcd_step = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_DIVN: begin
				if (sts.div_done) begin
					cmd.quot_num_load = 1'b1;
					cmd.div_start     = 1'b1;
					cmd.div_sel       = DSEL_DEN;
					state_d           = ST_DIVD;
				end
			end
			ST_DIVD: begin
				if (sts.div_done) begin
					cmd.quot_den_load = 1'b1;
					state_d           = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output beat overwritten");

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL1))
		else $error("accepted beat did not start multiply");

	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_GCD || state_q == ST_DIVN || state_q == ST_DIVD))
		else $error("divider finished with no one waiting");

	a_drain_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && !cmd.out_load) |=> !out_valid_q)
		else $error("output valid held after beat taken");
`endif

endmodule

### hw/rtl/rational_divide_compare_unit.sv
// ----------------------------------------------------------------------------
// rational_divide_compare_unit
// Reduces, divides and compares signed fractions p/q and r/s.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries opcode and the four operands;
//   output channel out_valid/out_ready carries num_result, den_result,
//   compare_true and zero_gcd_error. One result beat per input beat.
//   Compare ops and unused opcodes pass through MUL1, MUL2, DISPATCH and
//   FINISH, where the result goes into the output register. Reduce and
//   divide run Euclid's algorithm on a shared one-bit-per-cycle divider of
//   2*OPERAND_WIDTH bits: each remainder step is one divider run, and the
//   two reducing divisions follow unless the gcd is zero. One item is in
//   work at a time: the next beat is taken in the cycle after the result is
//   loaded.
//   in_ready is high whenever the sequencer is idle, also while a result
//   still waits in the output register; if the receiver stalls, a finished
//   item waits until that register frees, then in_ready rises again.
//   Reset (arst_n low) empties the unit: no result pending, ready to accept.
// ----------------------------------------------------------------------------
module rational_divide_compare_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rdc_pkg::opcode_t  opcode,
	input  rdc_pkg::operand_t num_first,
	input  rdc_pkg::operand_t den_first,
	input  rdc_pkg::operand_t num_second,
	input  rdc_pkg::operand_t den_second,
	output logic              out_valid,
	input  logic              out_ready,
	output rdc_pkg::result_t  num_result,
	output rdc_pkg::result_t  den_result,
	output logic              compare_true,
	output logic              zero_gcd_error
);
	import rdc_pkg::*;

	rdc_cmd_t cmd;
	rdc_sts_t sts;

	rdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rdc_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.num_first      (num_first),
		.den_first      (den_first),
		.num_second     (num_second),
		.den_second     (den_second),
		.num_result     (num_result),
		.den_result     (den_result),
		.compare_true   (compare_true),
		.zero_gcd_error (zero_gcd_error)
	);

endmodule

### bench/tb_rational_divide_compare_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_divide_compare_unit
// Self-checking bench for the rational reduce, divide and compare unit.
// Every accepted input beat is run through a local model of the Euclid
// reduction and the cross-product compares; every output beat is checked
// field by field against the oldest outcome still due. Both channels stall
// at random, with one stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module tb_rational_divide_compare_unit;
	import rdc_pkg::*;

	// Opcodes the unit does not define; they must give an all-zero result
	localparam opcode_t OP_SPARE_LO = 3'd5;
	localparam opcode_t OP_SPARE_HI = 3'd7;

	localparam int  RANDOM_ITEMS  = 1200;
	localparam int  IDLE_PERCENT  = 24;
	localparam int  DRAIN_CYCLES  = 2000;
	localparam int  MAX_PRINTED   = 40;
	localparam longint CYCLE_LIMIT = 10_000_000;

	typedef struct {
		result_t num;
		result_t den;
		logic    cmp;
		logic    zero_gcd;
	} rational_outcome_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	opcode_t   opcode = OP_REDUCE;
	operand_t  num_first = '0;
	operand_t  den_first = '0;
	operand_t  num_second = '0;
	operand_t  den_second = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	result_t   num_result;
	result_t   den_result;
	logic      compare_true;
	logic      zero_gcd_error;

	rational_outcome_t outcomes_due[$];
	int                fail_count = 0;
	longint            cycle_count = 0;
	bit                steady = 1'b0;

	rational_divide_compare_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.num_first     (num_first),
		.den_first     (den_first),
		.num_second    (num_second),
		.den_second    (den_second),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.num_result    (num_result),
		.den_result    (den_result),
		.compare_true  (compare_true),
		.zero_gcd_error(zero_gcd_error)
	);

	always #5 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Divide n and d by their Euclid gcd; remainder truncates toward zero
	// and takes the sign of the dividend, so the gcd may come out negative
	function automatic void reduce_by_gcd(input longint n, input longint d,
			output result_t rn, output result_t rd, output logic zero_gcd);
		longint x, y, t;
		x = n;
		y = d;
		while (y != 0) begin
			t = y;
			y = x % y;
			x = t;
		end
		if (x == 0) begin
			rn = '0;
			rd = '0;
			zero_gcd = 1'b1;
		end else begin
			rn = result_t'(n / x);
			rd = result_t'(d / x);
			zero_gcd = 1'b0;
		end
	endfunction

	function automatic rational_outcome_t predict_rational(input opcode_t op,
			input operand_t p, input operand_t q, input operand_t r, input operand_t s);
		rational_outcome_t o;
		longint lp, lq, lr, ls;
		result_t rn, rd;
		logic zg;
		lp = p;
		lq = q;
		lr = r;
		ls = s;
		o.num = '0;
		o.den = '0;
		o.cmp = 1'b0;
		o.zero_gcd = 1'b0;
		case (op)
			OP_REDUCE: begin
				reduce_by_gcd(lp, lq, rn, rd, zg);
				o.num = rn;
				o.den = rd;
				o.zero_gcd = zg;
			end
			OP_DIVIDE: begin
				reduce_by_gcd(lp * ls, lq * lr, rn, rd, zg);
				o.num = rn;
				o.den = rd;
				o.zero_gcd = zg;
			end
			OP_EQUAL:   o.cmp = (p == r) && (q == s);
			OP_GREATER: o.cmp = (lp * ls) > (lr * lq);
			OP_LESS:    o.cmp = (lp * ls) < (lr * lq);
			default:    ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_PRINTED)
			$display("%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Send one beat; valid stays up between back-to-back beats
	task automatic send_fraction(input opcode_t op, input operand_t p, input operand_t q,
			input operand_t r, input operand_t s);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		num_first  <= p;
		den_first  <= q;
		num_second <= r;
		den_second <= s;
		do
			@(posedge clk);
		while (!in_ready);
		outcomes_due.push_back(predict_rational(op, p, q, r, s));
	endtask

	// Check each output beat against the oldest outcome due; stall at random
	always @(posedge clk) begin
		rational_outcome_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (outcomes_due.size() == 0) begin
					report_mismatch("result beat with nothing due");
				end else begin
					want = outcomes_due.pop_front();
					if (num_result !== want.num)
						report_mismatch($sformatf("num_result %0d, want %0d",
							num_result, want.num));
					if (den_result !== want.den)
						report_mismatch($sformatf("den_result %0d, want %0d",
							den_result, want.den));
					if (compare_true !== want.cmp)
						report_mismatch($sformatf("compare_true %b, want %b",
							compare_true, want.cmp));
					if (zero_gcd_error !== want.zero_gcd)
						report_mismatch($sformatf("zero_gcd_error %b, want %b",
							zero_gcd_error, want.zero_gcd));
				end
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	function automatic operand_t pick_operand();
		case ($urandom_range(5))
			0, 1: return operand_t'($urandom);
			2: return operand_t'(int'($urandom_range(40)) - 20);
			3: return operand_t'(int'($urandom_range(2000)) - 1000);
			4: begin
				case ($urandom_range(4))
					0: return operand_t'(-32768);
					1: return operand_t'(32767);
					2: return operand_t'(-1);
					3: return operand_t'(0);
					default: return operand_t'(1);
				endcase
			end
			default: begin
				if ($urandom_range(1))
					return operand_t'(1 << $urandom_range(15));
				return operand_t'(-(1 << $urandom_range(15)));
			end
		endcase
	endfunction

	// Zero gcd, zero denominator alone, zero numerator, signs, extremes
	task automatic test_reduce_specials();
		send_fraction(OP_REDUCE, 0, 0, 0, 0);
		send_fraction(OP_REDUCE, 7, 0, 0, 0);
		send_fraction(OP_REDUCE, -7, 0, 0, 0);
		send_fraction(OP_REDUCE, 0, -5, 0, 0);
		send_fraction(OP_REDUCE, -12, 18, 0, 0);
		send_fraction(OP_REDUCE, 12, -18, 0, 0);
		send_fraction(OP_REDUCE, 32767, -32768, 0, 0);
		send_fraction(OP_REDUCE, -32768, -32768, 0, 0);
	endtask

	// Largest cross products, zero divisor, zero over zero
	task automatic test_divide_specials();
		send_fraction(OP_DIVIDE, -32768, 1, 1, -32768);
		send_fraction(OP_DIVIDE, 1, -32768, -32768, 1);
		send_fraction(OP_DIVIDE, 3, 4, 0, 5);
		send_fraction(OP_DIVIDE, 0, 4, 0, 5);
		send_fraction(OP_DIVIDE, -6, 35, 10, -21);
	endtask

	task automatic test_compare_ops();
		send_fraction(OP_EQUAL, -32768, 32767, -32768, 32767);
		send_fraction(OP_EQUAL, 5, 7, 10, 14);
		send_fraction(OP_GREATER, 1, 2, 1, 3);
		send_fraction(OP_LESS, 1, 2, 1, 3);
		send_fraction(OP_GREATER, 1, 2, 2, 4);
		send_fraction(OP_LESS, -32768, 1, 32767, 1);
		send_fraction(OP_GREATER, 32767, -32768, -32768, -32768);
	endtask

	task automatic test_unused_opcodes();
		send_fraction(OP_SPARE_LO, 9, 6, -4, 2);
		send_fraction(opcode_t'(OP_SPARE_LO + 1), -32768, 32767, 1, -1);
		send_fraction(OP_SPARE_HI, -1, -1, -1, -1);
	endtask

	// Mostly well-formed work with shared factors, some noise and spare codes
	task automatic test_random_mix();
		opcode_t  op;
		operand_t p, q, r, s;
		int       roll, k;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 400 && i < 600);
			roll = $urandom_range(99);
			if (roll < 30)
				op = OP_REDUCE;
			else if (roll < 55)
				op = OP_DIVIDE;
			else if (roll < 68)
				op = OP_EQUAL;
			else if (roll < 80)
				op = OP_GREATER;
			else if (roll < 94)
				op = OP_LESS;
			else
				op = opcode_t'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
			p = pick_operand();
			q = pick_operand();
			r = pick_operand();
			s = pick_operand();
			if ((op == OP_REDUCE || op == OP_DIVIDE) && $urandom_range(1)) begin
				k = $urandom_range(180, 1);
				p = operand_t'(k * (int'($urandom_range(360)) - 180));
				q = operand_t'(k * (int'($urandom_range(360)) - 180));
			end
			if (op == OP_EQUAL && $urandom_range(1)) begin
				r = p;
				s = q;
				if ($urandom_range(2) == 0)
					s = s ^ operand_t'(1 << $urandom_range(15));
			end
			send_fraction(op, p, q, r, s);
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reduce_specials();
		test_divide_specials();
		test_compare_ops();
		test_unused_opcodes();
		test_random_mix();
		in_valid <= 1'b0;
		// drain, then watch for stray beats
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (outcomes_due.size() != 0)
			report_mismatch("outcomes left over at end");
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
